// ===== rtl/eqrs_pkg.sv =====
// ----------------------------------------------------------------------------
// eqrs_pkg: shared types and constants
// Opcodes, event types, status bit positions and inter-module structs.
// ----------------------------------------------------------------------------
package eqrs_pkg;

    localparam int DEFAULT_FIFO_DEPTH = 8;
    localparam logic [3:0] THRESH_RESET = 4'd6;

    typedef enum logic [1:0] {
        OP_POST    = 2'd0,
        OP_RECEIVE = 2'd1,
        OP_ENABLE  = 2'd2,
        OP_DISABLE = 2'd3
    } op_t;

    localparam logic [1:0] TYPE_FAULT = 2'd0;
    localparam logic [1:0] TYPE_STALL = 2'd1;
    localparam logic [1:0] TYPE_INFO  = 2'd3;

    // status word bits examined by the enable snapshot
    localparam int BIT_FAULT_A = 13;
    localparam int BIT_FAULT_B = 9;
    localparam int BIT_FAULT_HI = 12;   // bits 12..11 >= 2 <=> bit 12 set
    localparam int BIT_STALL_A = 14;
    localparam int BIT_STALL_B = 15;

    typedef struct packed {
        logic [1:0]  etype;
        logic [15:0] status;
    } entry_t;

    // memory control from admission logic
    typedef struct packed {
        logic wr_first;     // write entry at write pointer
        logic wr_second;    // write stall entry at write pointer + 1, next cycle
        logic rd;           // read entry at read pointer
    } mem_ctl_t;

    // per-request result fields known at accept time
    typedef struct packed {
        logic        post_ok;
        logic        snap_fault;
        logic        snap_stall;
        logic        event_valid;
        logic [31:0] sent;
        logic [31:0] lost_crit;
        logic [31:0] lost_info;
        logic [3:0]  occupancy;
        logic [3:0]  mask;
    } res_t;

endpackage

// ===== rtl/eqrs_if.sv =====
// ----------------------------------------------------------------------------
// eqrs_if: request and result channel interfaces
// Valid/ready channels carrying the queue request and its result.
// ----------------------------------------------------------------------------
interface eqrs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [1:0]  event_type;
    logic [15:0] status_word;
    logic [3:0]  new_mask;

    modport source (output valid, opcode, event_type, status_word, new_mask,
                    input ready);
    modport sink   (input valid, opcode, event_type, status_word, new_mask,
                    output ready);
endinterface

interface eqrs_rsp_if;
    logic        valid;
    logic        ready;
    logic        post_ok;
    logic        snapshot_fault_queued;
    logic        snapshot_stall_queued;
    logic        event_valid;
    logic [1:0]  out_type;
    logic [15:0] out_status;
    logic [31:0] sent_total;
    logic [31:0] lost_critical_total;
    logic [31:0] lost_info_total;
    logic [3:0]  occupancy;
    logic [3:0]  mask_now;

    modport source (output valid, post_ok, snapshot_fault_queued,
                    snapshot_stall_queued, event_valid, out_type, out_status,
                    sent_total, lost_critical_total, lost_info_total,
                    occupancy, mask_now,
                    input ready);
    modport sink   (input valid, post_ok, snapshot_fault_queued,
                    snapshot_stall_queued, event_valid, out_type, out_status,
                    sent_total, lost_critical_total, lost_info_total,
                    occupancy, mask_now,
                    output ready);
endinterface

// ===== rtl/eqrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// eqrs_ctrl: admission, pointers and counters
// Decides each request in one pass and registers its result fields.
// ----------------------------------------------------------------------------
module eqrs_ctrl #(
    parameter int FIFO_DEPTH = eqrs_pkg::DEFAULT_FIFO_DEPTH,
    parameter int AW = $clog2(FIFO_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_wdata,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          opcode,
    input  logic [1:0]          event_type,
    input  logic [15:0]         status_word,
    input  logic [3:0]          new_mask,
    input  logic                pend_busy,
    input  logic                s1_take,
    output logic                s1_valid,
    output eqrs_pkg::res_t      s1_res,
    output eqrs_pkg::mem_ctl_t  mem_ctl,
    output logic [AW-1:0]       wr_addr,
    output logic [AW-1:0]       wr_addr_second,
    output logic [AW-1:0]       rd_addr,
    output logic [1:0]          first_type
);
    import eqrs_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);

    typedef struct packed {
        logic push;
        logic lost_crit;
        logic lost_info;
    } adm_t;

    logic [3:0]    thresh_reg;
    logic [3:0]    mask_reg, mask_next;
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next, fill_mid;
    logic [31:0]   sent_reg, sent_next;
    logic [31:0]   lcrit_reg, lcrit_next;
    logic [31:0]   linfo_reg, linfo_next;
    logic          s1_valid_reg, s1_valid_next;
    res_t          s1_res_reg, s1_res_next;
    adm_t          a_post, a_fault, a_stall;
    logic          accept, deq, fault_cond, stall_cond;
    logic [1:0]    n_push, n_crit, n_info;
    op_t           op;

    function automatic adm_t admit(input logic [3:0] mask, input logic [1:0] etype,
                                   input logic [CW-1:0] fill, input logic [3:0] thr);
        adm_t a;
        logic info;
        a = '0;
        info = (etype == TYPE_INFO);
        if (mask[etype])
        begin
            if (info && ({4'b0, fill} >= {{CW{1'b0}}, thr}))
                a.lost_info = 1'b1;
            else if (fill >= DEPTH_CNT)
            begin
                if (info)
                    a.lost_info = 1'b1;
                else
                    a.lost_crit = 1'b1;
            end
            else
                a.push = 1'b1;
        end
        return a;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    assign op         = op_t'(opcode);
    assign req_ready  = !pend_busy && (!s1_valid_reg || s1_take);
    assign accept     = req_valid && req_ready;
    assign fault_cond = !status_word[BIT_FAULT_A] || !status_word[BIT_FAULT_B]
                        || status_word[BIT_FAULT_HI];
    assign stall_cond = !status_word[BIT_STALL_A] || !status_word[BIT_STALL_B];

    always_comb
    begin
        a_post     = '0;
        a_fault    = '0;
        a_stall    = '0;
        deq        = 1'b0;
        mask_next  = mask_reg;
        first_type = event_type;
        fill_mid   = count_reg;
        case (op)
            OP_POST:
            begin
                a_post = admit(mask_reg, event_type, count_reg, thresh_reg);
            end
            OP_RECEIVE:
            begin
                deq = (count_reg != '0);
            end
            OP_ENABLE:
            begin
                mask_next = new_mask;
                if (new_mask != 4'd0)
                begin
                    if (fault_cond)
                        a_fault = admit(new_mask, TYPE_FAULT, count_reg, thresh_reg);
                    fill_mid = count_reg + {{(CW-1){1'b0}}, a_fault.push};
                    if (stall_cond)
                        a_stall = admit(new_mask, TYPE_STALL, fill_mid, thresh_reg);
                end
                first_type = a_fault.push ? TYPE_FAULT : TYPE_STALL;
            end
            OP_DISABLE:
            begin
                mask_next = 4'd0;
            end
            default:
            begin
                mask_next = mask_reg;
            end
        endcase
    end

    assign n_push = 2'(a_post.push) + 2'(a_fault.push) + 2'(a_stall.push);
    assign n_crit = 2'(a_post.lost_crit) + 2'(a_fault.lost_crit) + 2'(a_stall.lost_crit);
    assign n_info = 2'(a_post.lost_info) + 2'(a_fault.lost_info) + 2'(a_stall.lost_info);

    always_comb
    begin
        mem_ctl.wr_first  = accept && (n_push != 2'd0);
        mem_ctl.wr_second = accept && a_fault.push && a_stall.push;
        mem_ctl.rd        = accept && deq;
        wp_next    = wp_reg;
        if (n_push == 2'd1)
            wp_next = ptr_inc(wp_reg);
        else if (n_push == 2'd2)
            wp_next = ptr_inc(ptr_inc(wp_reg));
        rp_next    = deq ? ptr_inc(rp_reg) : rp_reg;
        count_next = count_reg + CW'(n_push) - CW'(deq);
        sent_next  = sent_reg + 32'(n_push);
        lcrit_next = lcrit_reg + 32'(n_crit);
        linfo_next = linfo_reg + 32'(n_info);

        s1_res_next.post_ok     = a_post.push;
        s1_res_next.snap_fault  = a_fault.push;
        s1_res_next.snap_stall  = a_stall.push;
        s1_res_next.event_valid = deq;
        s1_res_next.sent        = sent_next;
        s1_res_next.lost_crit   = lcrit_next;
        s1_res_next.lost_info   = linfo_next;
        s1_res_next.occupancy   = 4'(count_next);
        s1_res_next.mask        = mask_next;

        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_take)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign wr_addr        = wp_reg;
    assign wr_addr_second = ptr_inc(wp_reg);
    assign rd_addr        = rp_reg;
    assign s1_valid       = s1_valid_reg;
    assign s1_res         = s1_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg   <= THRESH_RESET;
            mask_reg     <= '0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            count_reg    <= '0;
            sent_reg     <= '0;
            lcrit_reg    <= '0;
            linfo_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thresh_reg <= cfg_wdata;
            if (accept)
            begin
                mask_reg  <= mask_next;
                wp_reg    <= wp_next;
                rp_reg    <= rp_next;
                count_reg <= count_next;
                sent_reg  <= sent_next;
                lcrit_reg <= lcrit_next;
                linfo_reg <= linfo_next;
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_res_reg <= s1_res_next;
    end

endmodule

// ===== rtl/eqrs_mem.sv =====
// ----------------------------------------------------------------------------
// eqrs_mem: event storage
// Single write port; the second snapshot write is registered and done in the next cycle.
// ----------------------------------------------------------------------------
module eqrs_mem #(
    parameter int FIFO_DEPTH = eqrs_pkg::DEFAULT_FIFO_DEPTH,
    parameter int AW = $clog2(FIFO_DEPTH)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  eqrs_pkg::mem_ctl_t  mem_ctl,
    input  logic [AW-1:0]       wr_addr,
    input  logic [AW-1:0]       wr_addr_second,
    input  logic [AW-1:0]       rd_addr,
    input  logic [1:0]          first_type,
    input  logic [15:0]         status_word,
    output logic                pend_busy,
    output eqrs_pkg::entry_t    rd_data
);
    import eqrs_pkg::*;

    entry_t        mem [FIFO_DEPTH];
    entry_t        rd_data_reg;
    logic          pend_reg;
    logic [AW-1:0] pend_addr_reg;
    logic [15:0]   pend_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else
            pend_reg <= mem_ctl.wr_second;
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_second)
        begin
            pend_addr_reg   <= wr_addr_second;
            pend_status_reg <= status_word;
        end
    end

    // no request is taken while the deferred write is busy, so ports never collide
    always_ff @(posedge clk)
    begin
        if (mem_ctl.wr_first)
            mem[wr_addr] <= '{etype: first_type, status: status_word};
        else if (pend_reg)
            mem[pend_addr_reg] <= '{etype: TYPE_STALL, status: pend_status_reg};
        if (mem_ctl.rd)
            rd_data_reg <= mem[rd_addr];
    end

    assign pend_busy = pend_reg;
    assign rd_data   = rd_data_reg;

endmodule

// ===== rtl/eqrs_out.sv =====
// ----------------------------------------------------------------------------
// eqrs_out: result register
// Merges read data with the staged fields and holds the result until taken.
// ----------------------------------------------------------------------------
module eqrs_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s1_valid,
    input  eqrs_pkg::res_t     s1_res,
    input  eqrs_pkg::entry_t   rd_data,
    output logic               s1_take,
    eqrs_rsp_if.source         result
);
    import eqrs_pkg::*;

    logic   out_valid_reg;
    res_t   res_reg;
    entry_t ent_reg;

    assign s1_take = s1_valid && (!out_valid_reg || result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_take)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_take)
        begin
            res_reg <= s1_res;
            ent_reg <= s1_res.event_valid ? rd_data : '0;
        end
    end

    assign result.valid                 = out_valid_reg;
    assign result.post_ok               = res_reg.post_ok;
    assign result.snapshot_fault_queued = res_reg.snap_fault;
    assign result.snapshot_stall_queued = res_reg.snap_stall;
    assign result.event_valid           = res_reg.event_valid;
    assign result.out_type              = ent_reg.etype;
    assign result.out_status            = ent_reg.status;
    assign result.sent_total            = res_reg.sent;
    assign result.lost_critical_total   = res_reg.lost_crit;
    assign result.lost_info_total       = res_reg.lost_info;
    assign result.occupancy             = res_reg.occupancy;
    assign result.mask_now              = res_reg.mask;

endmodule

// ===== rtl/event_queue_reserved_slot.sv =====
// ----------------------------------------------------------------------------
// event_queue_reserved_slot: event FIFO with reserved-slot admission
// Posts, receives, enable with status snapshot and disable, one per request.
// ----------------------------------------------------------------------------
// Result path: staged fields are registered at accept, then moved into the result register.
// Throughput: one request per cycle while results are taken; an enable that
//   queues both snapshot events holds off the next request during the second entry write.
// Reset: asynchronous, active low; queue empty, all types masked off,
//   counters zero, threshold 6; entry storage is not cleared.
module event_queue_reserved_slot #(
    parameter int FIFO_DEPTH = eqrs_pkg::DEFAULT_FIFO_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [3:0]   cfg_wdata,
    eqrs_req_if.sink     request,
    eqrs_rsp_if.source   result
);
    import eqrs_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    // admission stage outputs
    logic          s1_valid;
    logic          s1_take;
    res_t          s1_res;
    mem_ctl_t      mem_ctl;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] wr_addr_second;
    logic [AW-1:0] rd_addr;
    logic [1:0]    first_type;

    // storage outputs
    logic          pend_busy;
    entry_t        rd_data;

    // Admission: type mask, reserved threshold and full checks, pointer and
    // counter updates; both snapshot posts are decided in the same pass.
    eqrs_ctrl #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .req_valid      (request.valid),
        .req_ready      (request.ready),
        .opcode         (request.opcode),
        .event_type     (request.event_type),
        .status_word    (request.status_word),
        .new_mask       (request.new_mask),
        .pend_busy      (pend_busy),
        .s1_take        (s1_take),
        .s1_valid       (s1_valid),
        .s1_res         (s1_res),
        .mem_ctl        (mem_ctl),
        .wr_addr        (wr_addr),
        .wr_addr_second (wr_addr_second),
        .rd_addr        (rd_addr),
        .first_type     (first_type)
    );

    // Entry storage: registered read lines up with the admission stage.
    eqrs_mem #(
        .FIFO_DEPTH (FIFO_DEPTH),
        .AW         (AW)
    ) u_mem (
        .clk            (clk),
        .rst_n          (rst_n),
        .mem_ctl        (mem_ctl),
        .wr_addr        (wr_addr),
        .wr_addr_second (wr_addr_second),
        .rd_addr        (rd_addr),
        .first_type     (first_type),
        .status_word    (request.status_word),
        .pend_busy      (pend_busy),
        .rd_data        (rd_data)
    );

    // Result register: lets a new request enter while a result waits.
    eqrs_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_res   (s1_res),
        .rd_data  (rd_data),
        .s1_take  (s1_take),
        .result   (result)
    );

endmodule
